@@ rtl/rrjs_pkg.sv @@
// Shared types, codes and constants of the round-robin job scheduler.
package rrjs_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int ID_W       = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int ENTRY_W    = ID_W + TIME_W;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 88;
    localparam int EV_W       = 3;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_W-1:0] TIME_SLICE_RST = 16'd4;
    localparam logic [CFG_W-1:0] LOAD_DELAY_RST = 16'd0;

    localparam logic [CFG_ADDR_W-1:0] CFG_TIME_SLICE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOAD_DELAY = 1'b1;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 3'd0,
        EV_LOAD    = 3'd1,
        EV_START   = 3'd2,
        EV_FINISH  = 3'd3,
        EV_TIMEOUT = 3'd4,
        EV_ADDED   = 3'd5,
        EV_FULL    = 3'd6
    } ev_t;

    typedef struct packed {
        ev_t                ev;
        logic [ID_W-1:0]    job;
        logic [TIME_W-1:0]  tm;
        logic [TIME_W-1:0]  left;
        logic               waiting;
        logic               last;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND0,
        ST_SEND1
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic sel_second;
    } cmd_t;

    typedef struct packed {
        logic need_exec;
        logic two;
    } stat_t;

endpackage

@@ rtl/rrjs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rrjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rrjs_ctrl.sv @@
// Control state machine of the round-robin job scheduler.
module rrjs_ctrl
    import rrjs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.exec       = 1'b0;
        cmd.sel_second = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = st.need_exec ? ST_EXEC : ST_SEND0;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_SEND0;
            end
            ST_SEND0: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = st.two ? ST_SEND1 : ST_IDLE;
                end
            end
            ST_SEND1: begin
                m_tvalid       = 1'b1;
                cmd.sel_second = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_send1_after_send0: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND1) |-> ($past(state_reg) == ST_SEND0 ||
                                     $past(state_reg) == ST_SEND1))
        else $error("second result without first");
    a_exec_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> $past(cmd.accept))
        else $error("head update without accepted item");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while result pending");
`endif

endmodule

@@ rtl/rrjs_dp.sv @@
// Datapath of the round-robin job scheduler: queue, counters and result registers.
module rrjs_dp
    import rrjs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  cmd_t                  cmd,
    output stat_t                 st,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [EV_W-1:0]       m_tuser,
    output logic                  m_tlast
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CFG_W-1:0]  time_slice_reg;
    logic [CFG_W-1:0]  load_delay_reg;
    logic [PTR_W-1:0]  head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]  tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0]  job_count_reg, job_count_next;
    logic [CFG_W-1:0]  slice_left_reg, slice_left_next;
    logic [CFG_W-1:0]  load_left_reg, load_left_next;
    logic [TIME_W-1:0] cycle_count_reg, cycle_count_next;
    logic              two_reg, two_next;
    res_t              res0_reg, res0_next;
    res_t              res1_reg, res1_next;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              in_tick;
    logic [ID_W-1:0]   in_id;
    logic [TIME_W-1:0] in_time;
    logic [ID_W-1:0]   head_id;
    logic [TIME_W-1:0] head_rem;
    logic              q_full;
    logic              q_empty;
    res_t              cur;

    function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic res_t mk_res(input ev_t ev, input logic [ID_W-1:0] job,
                                    input logic [TIME_W-1:0] tm,
                                    input logic [TIME_W-1:0] left,
                                    input logic waiting, input logic last);
        res_t r;
        r.ev      = ev;
        r.job     = job;
        r.tm      = tm;
        r.left    = left;
        r.waiting = waiting;
        r.last    = last;
        return r;
    endfunction

    rrjs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(head_ptr_reg),
        .rdata(ram_rdata)
    );

    assign in_tick  = (s_tuser == REQ_TICK);
    assign in_id    = s_tdata[ID_W-1:0];
    assign in_time  = s_tdata[ENTRY_W-1:ID_W];
    assign head_id  = ram_rdata[ID_W-1:0];
    assign head_rem = ram_rdata[ENTRY_W-1:ID_W];
    assign q_full   = (job_count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty  = (job_count_reg == '0);

    assign st.need_exec = in_tick && !q_empty;
    assign st.two       = two_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_slice_reg <= TIME_SLICE_RST;
            load_delay_reg <= LOAD_DELAY_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_TIME_SLICE: time_slice_reg <= cfg_wdata;
                CFG_LOAD_DELAY: load_delay_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_ptr_reg    <= '0;
            tail_ptr_reg    <= '0;
            job_count_reg   <= '0;
            slice_left_reg  <= TIME_SLICE_RST;
            load_left_reg   <= LOAD_DELAY_RST;
            cycle_count_reg <= '0;
            two_reg         <= 1'b0;
        end else begin
            head_ptr_reg    <= head_ptr_next;
            tail_ptr_reg    <= tail_ptr_next;
            job_count_reg   <= job_count_next;
            slice_left_reg  <= slice_left_next;
            load_left_reg   <= load_left_next;
            cycle_count_reg <= cycle_count_next;
            two_reg         <= two_next;
        end
    end

    always_ff @(posedge aclk) begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    always_comb begin
        logic              start;
        logic [CFG_W-1:0]  sl;
        logic [TIME_W-1:0] cyc1;
        logic              wait_after;
        head_ptr_next    = head_ptr_reg;
        tail_ptr_next    = tail_ptr_reg;
        job_count_next   = job_count_reg;
        slice_left_next  = slice_left_reg;
        load_left_next   = load_left_reg;
        cycle_count_next = cycle_count_reg;
        two_next         = two_reg;
        res0_next        = res0_reg;
        res1_next        = res1_reg;
        ram_we           = 1'b0;
        ram_waddr        = tail_ptr_reg;
        ram_wdata        = {in_time, in_id};
        start            = (slice_left_reg == time_slice_reg);
        sl               = slice_left_reg - 1'b1;
        cyc1             = cycle_count_reg + 1'b1;
        wait_after       = (job_count_reg != CNT_W'(1));

        if (cmd.accept) begin
            two_next = 1'b0;
            if (!in_tick) begin
                if (q_full) begin
                    res0_next = mk_res(EV_FULL, in_id, cycle_count_reg, '0, 1'b1, 1'b1);
                end else begin
                    ram_we         = 1'b1;
                    tail_ptr_next  = nxt(tail_ptr_reg);
                    job_count_next = job_count_reg + 1'b1;
                    res0_next = mk_res(EV_ADDED, in_id, cycle_count_reg, '0, 1'b1, 1'b1);
                end
            end else begin
                cycle_count_next = cyc1;
                if (q_empty) begin
                    res0_next = mk_res(EV_NONE, '0, cyc1, '0, 1'b0, 1'b1);
                end
            end
        end

        if (cmd.exec) begin
            two_next = 1'b0;
            if (load_left_reg != '0) begin
                load_left_next = load_left_reg - 1'b1;
                if (load_left_reg == load_delay_reg) begin
                    res0_next = mk_res(EV_LOAD, head_id, cycle_count_reg, '0, 1'b1, 1'b1);
                end else begin
                    res0_next = mk_res(EV_NONE, '0, cycle_count_reg, '0, 1'b1, 1'b1);
                end
            end else if (head_rem <= TIME_W'(1)) begin
                head_ptr_next   = nxt(head_ptr_reg);
                job_count_next  = job_count_reg - 1'b1;
                slice_left_next = time_slice_reg;
                load_left_next  = load_delay_reg;
                if (start) begin
                    two_next  = 1'b1;
                    res0_next = mk_res(EV_START, head_id, cycle_count_reg, head_rem,
                                       wait_after, 1'b0);
                    res1_next = mk_res(EV_FINISH, head_id, cyc1, '0, wait_after, 1'b1);
                end else begin
                    res0_next = mk_res(EV_FINISH, head_id, cyc1, '0, wait_after, 1'b1);
                end
            end else begin
                ram_we    = 1'b1;
                ram_wdata = {head_rem - 1'b1, head_id};
                if (sl == '0) begin
                    ram_waddr       = tail_ptr_reg;
                    head_ptr_next   = nxt(head_ptr_reg);
                    tail_ptr_next   = nxt(tail_ptr_reg);
                    slice_left_next = time_slice_reg;
                    if (wait_after) begin
                        load_left_next = load_delay_reg;
                    end
                    if (start) begin
                        two_next  = 1'b1;
                        res0_next = mk_res(EV_START, head_id, cycle_count_reg, head_rem,
                                           1'b1, 1'b0);
                        res1_next = mk_res(EV_TIMEOUT, head_id, cyc1, '0, 1'b1, 1'b1);
                    end else begin
                        res0_next = mk_res(EV_TIMEOUT, head_id, cyc1, '0, 1'b1, 1'b1);
                    end
                end else begin
                    ram_waddr       = head_ptr_reg;
                    slice_left_next = sl;
                    if (start) begin
                        res0_next = mk_res(EV_START, head_id, cycle_count_reg, head_rem,
                                           1'b1, 1'b1);
                    end else begin
                        res0_next = mk_res(EV_NONE, '0, cycle_count_reg, '0, 1'b1, 1'b1);
                    end
                end
            end
        end
    end

    assign cur     = cmd.sel_second ? res1_reg : res0_reg;
    assign m_tuser = cur.ev;
    assign m_tlast = cur.last;
    assign m_tdata = {7'd0, cur.waiting, cur.left, cur.tm, cur.job};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        job_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("job count beyond queue depth");
    a_ptrs_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_count_reg == '0 || job_count_reg == CNT_W'(QUEUE_DEPTH)) |->
        (head_ptr_reg == tail_ptr_reg))
        else $error("pointers disagree with job count");
    a_cycle_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (cycle_count_reg != $past(cycle_count_reg)) |-> $past(cmd.accept && in_tick))
        else $error("cycle count moved without tick");
`endif

endmodule

@@ rtl/round_robin_job_scheduler.sv @@
// Top level of the round-robin job scheduler.
// Usage:
//   s_* channel takes one request item: s_tuser selects add (0) or tick (1);
//   an add carries the job id and its run time in s_tdata.
//   m_* channel returns one or two result items per request; m_tuser holds
//   the event code and m_tlast marks the final result of a request.
//   cfg_we/cfg_addr/cfg_wdata write time_slice (index 0) or load_delay
//   (index 1); write only while no request is in flight.
// Timing:
//   One request at a time. An add or a tick on an empty queue shows its
//   result in the cycle after acceptance. A tick on a busy queue reads the
//   head job from the job memory (registered read) and updates it in the
//   EXEC state; its first result is registered from that update.
// Reset:
//   aresetn (synchronous, active low) empties the queue, clears the cycle
//   counter and restores time_slice = 4, load_delay = 0.
// Stall:
//   While m_tready is low the pending result holds and s_tready stays low.
module round_robin_job_scheduler
    import rrjs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // job_id[15:0], job_time[47:16]
    input  logic                  s_tuser,   // req_type[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // event_job[15:0], event_time[47:16],
                                             // time_left[79:48], jobs_waiting[80]
    output logic [EV_W-1:0]       m_tuser,   // event_res[2:0]
    output logic                  m_tlast
);

    cmd_t  cmd;
    stat_t st;

    rrjs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .st      (st),
        .cmd     (cmd)
    );

    rrjs_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .st       (st),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
